@@ hdl/ucl_pkg.sv @@
// Shared types, widths and constants for the uniform grid cell locator.
package ucl_pkg;

  localparam int COORD_W    = 32;
  localparam int RADIUS_W   = 31;
  localparam int CELL_W     = 9;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COUNTS_W   = 24;
  localparam int PROD_W     = 64;

  localparam int COUNT_BITS = 8;
  localparam int MAX_REACH  = 1;
  localparam int REACH_W    = $clog2(MAX_REACH + 2);

  // Bin indices saturate at plus or minus IDX_LIMIT.
  localparam int IDX_LIMIT  = 1048576;
  localparam int Q_W        = 21;
  localparam int IDX_W      = 22;

  localparam int CELL_MIN   = -128;
  localparam int CELL_MAX   = 255;

  localparam logic [CFG_W-1:0]    SCALE_RESET  = 32'd65536;
  localparam logic [CFG_W-1:0]    INV_RESET    = 32'd65536;
  localparam logic [COUNTS_W-1:0] COUNTS_RESET = 24'd65793;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_SCALE_X    = 3'd3,
    REG_SCALE_Y    = 3'd4,
    REG_SCALE_Z    = 3'd5,
    REG_CELL_COUNT = 3'd6,
    REG_INV_WIDTH  = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_R
  } mul_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_Z,
    S_MUL_R,
    S_REACH,
    S_SETUP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     setup;
    logic     ins_load;
    logic     emit_load;
  } dp_ctl_t;

  typedef struct packed {
    logic is_query;
    logic empty;
    logic last_cell;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/ucl_ctrl.sv @@
// Sequencing state machine for the uniform grid cell locator.
module ucl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ucl_pkg::dp_status_t sts,
  output ucl_pkg::dp_ctl_t    ctl
);
  import ucl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.mul_sel = SEL_NONE;
    req_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_MUL_X;
        end
      end
      S_MUL_X: begin
        ctl.mul_sel = SEL_X;
        state_next  = S_MUL_Y;
      end
      S_MUL_Y: begin
        ctl.mul_sel = SEL_Y;
        state_next  = S_MUL_Z;
      end
      S_MUL_Z: begin
        ctl.mul_sel = SEL_Z;
        state_next  = S_MUL_R;
      end
      S_MUL_R: begin
        ctl.mul_sel = SEL_R;
        state_next  = S_REACH;
      end
      S_REACH: begin
        state_next = S_SETUP;
      end
      S_SETUP: begin
        if (sts.is_query) begin
          ctl.setup  = 1'b1;
          state_next = sts.empty ? S_IDLE : S_EMIT;
        end else if (sts.out_free) begin
          ctl.ins_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_load = 1'b1;
          if (sts.last_cell) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/ucl_dp.sv @@
// Datapath: configuration registers, shared multiplier, binning, ranges and result register.
module ucl_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [ucl_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ucl_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                    cmd,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_x,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_y,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_z,
  input  logic [ucl_pkg::RADIUS_W-1:0]            radius_value,
  input  ucl_pkg::dp_ctl_t                        ctl,
  output ucl_pkg::dp_status_t                     sts,
  output logic                                    rsp_valid,
  input  logic                                    rsp_stall,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_x,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_y,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_z,
  output logic                                    in_bounds,
  output logic [ucl_pkg::RADIUS_W-1:0]            radius_min,
  output logic [ucl_pkg::RADIUS_W-1:0]            radius_max,
  output logic                                    last
);
  import ucl_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]    origin_x, origin_y, origin_z;
  logic [CFG_W-1:0]    scale_x, scale_y, scale_z;
  logic [COUNTS_W-1:0] cell_counts;
  logic [CFG_W-1:0]    inv_cell_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      origin_z       <= '0;
      scale_x        <= SCALE_RESET;
      scale_y        <= SCALE_RESET;
      scale_z        <= SCALE_RESET;
      cell_counts    <= COUNTS_RESET;
      inv_cell_width <= INV_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ORIGIN_X:   origin_x       <= cfg_data;
        REG_ORIGIN_Y:   origin_y       <= cfg_data;
        REG_ORIGIN_Z:   origin_z       <= cfg_data;
        REG_SCALE_X:    scale_x        <= cfg_data;
        REG_SCALE_Y:    scale_y        <= cfg_data;
        REG_SCALE_Z:    scale_z        <= cfg_data;
        REG_CELL_COUNT: cell_counts    <= cfg_data[COUNTS_W-1:0];
        REG_INV_WIDTH:  inv_cell_width <= cfg_data;
      endcase
    end
  end

  // Capture: per axis the magnitude and sign of coord minus origin.
  logic signed [COORD_W:0] diff_x, diff_y, diff_z;
  logic signed [COORD_W:0] ndiff_x, ndiff_y, ndiff_z;
  logic [COORD_W-1:0]      mag_x, mag_y, mag_z;
  logic                    neg_x, neg_y, neg_z;
  logic                    is_query;
  logic [RADIUS_W-1:0]     radius;

  always_comb begin
    diff_x  = $signed({coord_x[COORD_W-1], coord_x}) -
              $signed({origin_x[COORD_W-1], origin_x});
    diff_y  = $signed({coord_y[COORD_W-1], coord_y}) -
              $signed({origin_y[COORD_W-1], origin_y});
    diff_z  = $signed({coord_z[COORD_W-1], coord_z}) -
              $signed({origin_z[COORD_W-1], origin_z});
    ndiff_x = -diff_x;
    ndiff_y = -diff_y;
    ndiff_z = -diff_z;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      is_query <= cmd;
      radius   <= radius_value;
      neg_x    <= diff_x[COORD_W];
      neg_y    <= diff_y[COORD_W];
      neg_z    <= diff_z[COORD_W];
      mag_x    <= diff_x[COORD_W] ? ndiff_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
      mag_y    <= diff_y[COORD_W] ? ndiff_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
      mag_z    <= diff_z[COORD_W] ? ndiff_z[COORD_W-1:0] : diff_z[COORD_W-1:0];
    end
  end

  // Shared 32 by 32 multiplier, one product a cycle, tagged with its operand.
  logic [COORD_W-1:0] mul_a;
  logic [CFG_W-1:0]   mul_b;
  logic               mul_neg;
  logic [PROD_W-1:0]  prod;
  logic               prod_neg;
  mul_sel_t           prod_sel;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (ctl.mul_sel)
      SEL_X: begin
        mul_a   = mag_x;
        mul_b   = scale_x;
        mul_neg = neg_x;
      end
      SEL_Y: begin
        mul_a   = mag_y;
        mul_b   = scale_y;
        mul_neg = neg_y;
      end
      SEL_Z: begin
        mul_a   = mag_z;
        mul_b   = scale_z;
        mul_neg = neg_z;
      end
      SEL_R: begin
        mul_a = {1'b0, radius};
        mul_b = inv_cell_width;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_sel <= SEL_NONE;
    end else begin
      prod_sel <= ctl.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_neg <= mul_neg;
  end

  // Floor of a signed product: round the magnitude up when the fraction is
  // nonzero on the negative side, then saturate and restore the sign.
  logic [COORD_W:0]        q_full;
  logic [Q_W-1:0]          q_sat;
  logic signed [IDX_W-1:0] idx_conv;
  logic [COORD_W:0]        r_full;
  logic [REACH_W-1:0]      reach_conv;
  logic                    frac_nz;

  always_comb begin
    frac_nz = |prod[COORD_W-1:0];
    q_full  = {1'b0, prod[PROD_W-1:COORD_W]} + (COORD_W+1)'(prod_neg & frac_nz);
    if (q_full > (COORD_W+1)'(IDX_LIMIT)) begin
      q_sat = Q_W'(IDX_LIMIT);
    end else begin
      q_sat = q_full[Q_W-1:0];
    end
    idx_conv = prod_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    r_full   = {1'b0, prod[PROD_W-1:COORD_W]} + (COORD_W+1)'(frac_nz);
    if (r_full > (COORD_W+1)'(MAX_REACH)) begin
      reach_conv = REACH_W'(MAX_REACH);
    end else begin
      reach_conv = r_full[REACH_W-1:0];
    end
  end

  logic signed [IDX_W-1:0] seed [3];
  logic [REACH_W-1:0]      reach;

  always_ff @(posedge clk) begin
    unique case (prod_sel)
      SEL_X:   seed[0] <= idx_conv;
      SEL_Y:   seed[1] <= idx_conv;
      SEL_Z:   seed[2] <= idx_conv;
      SEL_R:   reach   <= reach_conv;
      default: begin
      end
    endcase
  end

  // Per-axis neighbor range, clamped to the grid, and insert bounds test.
  logic [COUNT_BITS-1:0]   cnt     [3];
  logic signed [IDX_W:0]   seed_e  [3];
  logic signed [IDX_W:0]   cnt_e   [3];
  logic signed [IDX_W:0]   lo_full [3];
  logic signed [IDX_W:0]   hi_full [3];
  logic signed [IDX_W:0]   reach_e;
  logic [2:0]              axis_empty;
  logic [2:0]              axis_in;
  logic signed [CELL_W-1:0] seed_cell [3];

  always_comb begin
    reach_e = $signed({{(IDX_W+1-REACH_W){1'b0}}, reach});
    for (int a = 0; a < 3; a++) begin
      cnt[a]     = cell_counts[8*a +: COUNT_BITS];
      seed_e[a]  = {seed[a][IDX_W-1], seed[a]};
      cnt_e[a]   = $signed({{(IDX_W+1-COUNT_BITS){1'b0}}, cnt[a]});
      lo_full[a] = seed_e[a] - reach_e;
      if (lo_full[a] < 0) begin
        lo_full[a] = '0;
      end
      hi_full[a] = seed_e[a] + reach_e;
      if (hi_full[a] > cnt_e[a] - $signed((IDX_W+1)'(1))) begin
        hi_full[a] = cnt_e[a] - $signed((IDX_W+1)'(1));
      end
      axis_empty[a] = lo_full[a] > hi_full[a];
      axis_in[a]    = (seed_e[a] >= 0) && (seed_e[a] < cnt_e[a]);
      if (seed[a] < CELL_MIN) begin
        seed_cell[a] = CELL_W'(CELL_MIN);
      end else if (seed[a] > CELL_MAX) begin
        seed_cell[a] = CELL_W'(CELL_MAX);
      end else begin
        seed_cell[a] = seed[a][CELL_W-1:0];
      end
    end
  end

  // Radius statistics of accepted inserts.
  logic                any_accepted, any_next;
  logic [RADIUS_W-1:0] smallest_radius, smallest_next;
  logic [RADIUS_W-1:0] largest_radius, largest_next;
  logic                ins_inside;

  always_comb begin
    ins_inside    = &axis_in;
    any_next      = any_accepted;
    smallest_next = smallest_radius;
    largest_next  = largest_radius;
    if (ins_inside) begin
      priority if (!any_accepted) begin
        any_next      = 1'b1;
        smallest_next = radius;
        largest_next  = radius;
      end else if (radius > largest_radius) begin
        largest_next = radius;
      end else if (radius < smallest_radius) begin
        smallest_next = radius;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_accepted    <= 1'b0;
      smallest_radius <= '0;
      largest_radius  <= '0;
    end else if (ctl.ins_load) begin
      any_accepted    <= any_next;
      smallest_radius <= smallest_next;
      largest_radius  <= largest_next;
    end
  end

  // Neighbor enumeration counters, z innermost.
  logic [COUNT_BITS-1:0] lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [COUNT_BITS-1:0] cur_x, cur_y, cur_z;
  logic                  last_cell;

  assign last_cell = (cur_x == hi_x) && (cur_y == hi_y) && (cur_z == hi_z);

  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      cur_x <= lo_full[0][COUNT_BITS-1:0];
      cur_y <= lo_full[1][COUNT_BITS-1:0];
      cur_z <= lo_full[2][COUNT_BITS-1:0];
      lo_y  <= lo_full[1][COUNT_BITS-1:0];
      lo_z  <= lo_full[2][COUNT_BITS-1:0];
      hi_x  <= hi_full[0][COUNT_BITS-1:0];
      hi_y  <= hi_full[1][COUNT_BITS-1:0];
      hi_z  <= hi_full[2][COUNT_BITS-1:0];
    end else if (ctl.emit_load) begin
      if (cur_z == hi_z) begin
        cur_z <= lo_z;
        if (cur_y == hi_y) begin
          cur_y <= lo_y;
          cur_x <= cur_x + 1'b1;
        end else begin
          cur_y <= cur_y + 1'b1;
        end
      end else begin
        cur_z <= cur_z + 1'b1;
      end
    end
  end

  // Result register; a new result may load as the held one is taken.
  logic out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.ins_load || ctl.emit_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_load) begin
      cell_x     <= seed_cell[0];
      cell_y     <= seed_cell[1];
      cell_z     <= seed_cell[2];
      in_bounds  <= ins_inside;
      radius_min <= smallest_next;
      radius_max <= largest_next;
      last       <= 1'b1;
    end else if (ctl.emit_load) begin
      cell_x     <= $signed({{(CELL_W-COUNT_BITS){1'b0}}, cur_x});
      cell_y     <= $signed({{(CELL_W-COUNT_BITS){1'b0}}, cur_y});
      cell_z     <= $signed({{(CELL_W-COUNT_BITS){1'b0}}, cur_z});
      in_bounds  <= 1'b1;
      radius_min <= smallest_radius;
      radius_max <= largest_radius;
      last       <= last_cell;
    end
  end

  always_comb begin
    sts.is_query  = is_query;
    sts.empty     = |axis_empty;
    sts.last_cell = last_cell;
    sts.out_free  = out_free;
  end

endmodule

@@ hdl/uniform_grid_cell_locator_core.sv @@
// Top level of the uniform grid cell locator.
// A request is taken only while the block is idle, one at a time. The three
// axis products and the search reach product share one 32 by 32 multiplier,
// one product a cycle, and the neighbor ranges are set up once the three
// indices and the reach are registered. An insert then loads its single
// result when the output register is free, and the block returns to idle. A
// query sets up its ranges and then loads one neighbor cell per cycle while
// the output register is free, up to (2*MAX_REACH+1)^3 = 27 cells, stepped by
// the enumeration counters; a query whose clamped range is empty gives no
// result and returns to idle. A result that is stalled holds the block until
// it is taken. Results sit in an output register, so a new request is taken
// while the last result still waits to be taken.
module uniform_grid_cell_locator_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [ucl_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ucl_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                    req_valid,
  output logic                                    req_stall,
  input  logic                                    cmd,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_x,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_y,
  input  logic signed [ucl_pkg::COORD_W-1:0]      coord_z,
  input  logic [ucl_pkg::RADIUS_W-1:0]            radius_value,
  output logic                                    rsp_valid,
  input  logic                                    rsp_stall,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_x,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_y,
  output logic signed [ucl_pkg::CELL_W-1:0]       cell_z,
  output logic                                    in_bounds,
  output logic [ucl_pkg::RADIUS_W-1:0]            radius_min,
  output logic [ucl_pkg::RADIUS_W-1:0]            radius_max,
  output logic                                    last
);
  import ucl_pkg::*;

  dp_ctl_t    ctl;
  dp_status_t sts;

  ucl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ucl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .radius_value (radius_value),
    .ctl          (ctl),
    .sts          (sts),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .in_bounds    (in_bounds),
    .radius_min   (radius_min),
    .radius_max   (radius_max),
    .last         (last)
  );

endmodule
